@@ design/assert_macros.svh @@
// Assertion helper macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/mcfir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel FIR package
// Shared constants, opcodes and types of the multichannel FIR filter.
// ----------------------------------------------------------------------------
package mcfir_pkg;

  localparam int Taps      = 32;
  localparam int Channels  = 4;
  localparam int TapW      = $clog2(Taps);
  localparam int ChW       = 2;
  localparam int SampleW   = 10;
  localparam int CoefW     = 16;
  localparam int ProdW     = SampleW + 1 + CoefW;
  localparam int AccW      = ProdW + TapW;
  localparam int ShiftBits = 15;
  localparam int OutW      = 16;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic             smp_we;
    logic             coef_we;
    logic [ChW-1:0]   coef_ch;
    logic [TapW-1:0]  wr_ptr;
    logic [TapW-1:0]  coef_addr;
    logic             clear;
    logic             rd_en;
    logic [TapW-1:0]  rd_tap;
    logic [TapW-1:0]  rd_pos;
    logic             acc_en;
  } lane_ctrl_t;

endpackage

@@ design/mcfir_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel FIR lane
// One channel: sample ring, coefficient memory and a multiply-accumulate unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mcfir_lane
  import mcfir_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  lane_ctrl_t                ctrl,
  input  logic [SampleW-1:0]        sample,
  input  logic signed [CoefW-1:0]   weight,
  output logic signed [AccW-1:0]    acc,
  output logic [SampleW-1:0]        newest
);

  logic [SampleW-1:0]      ring_mem [Taps];
  logic signed [CoefW-1:0] coef_mem [Taps];
  logic [Taps-1:0]         coef_vld_r, coef_vld_nxt;
  logic [SampleW-1:0]      smp_rd_r;
  logic signed [CoefW-1:0] coef_rd_r;
  logic                    coef_hit_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [CoefW-1:0] coef_eff;

  // Ring slots are not reset; a slot read before it has been written
  // contributes zero, so the ring needs a valid bit too.
  logic [Taps-1:0]         smp_vld_r, smp_vld_nxt;
  logic                    smp_hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.smp_we) ring_mem[ctrl.wr_ptr] <= sample;
    if (ctrl.coef_we) coef_mem[ctrl.coef_addr] <= weight;
    smp_rd_r   <= ring_mem[ctrl.rd_pos];
    coef_rd_r  <= coef_mem[ctrl.rd_tap];
    smp_hit_r  <= smp_vld_r[ctrl.rd_pos];
    coef_hit_r <= coef_vld_r[ctrl.rd_tap];
  end

  always_comb begin
    smp_vld_nxt  = smp_vld_r;
    coef_vld_nxt = coef_vld_r;
    if (ctrl.smp_we) smp_vld_nxt[ctrl.wr_ptr] = 1'b1;
    if (ctrl.coef_we) coef_vld_nxt[ctrl.coef_addr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r  <= '0;
      coef_vld_r <= '0;
    end else begin
      smp_vld_r  <= smp_vld_nxt;
      coef_vld_r <= coef_vld_nxt;
    end
  end

  assign coef_eff = coef_hit_r ? coef_rd_r : CoefW'(1);

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, (smp_hit_r ? smp_rd_r : SampleW'(0))}) * coef_eff;
    if (ctrl.clear) acc_r <= '0;
    else if (ctrl.acc_en) acc_r <= acc_r + AccW'(prod_r);
  end

  assign acc    = acc_r;
  assign newest = smp_hit_r ? smp_rd_r : '0;

  `ASSERT_NEXT(a_ring_vld, clk, rst_n, ctrl.smp_we, smp_vld_r[$past(ctrl.wr_ptr)])
  `ASSERT_NEXT(a_coef_vld, clk, rst_n, ctrl.coef_we, coef_vld_r[$past(ctrl.coef_addr)])
  `ASSERT_IMP(a_clear_noacc, clk, rst_n, ctrl.clear, !ctrl.acc_en)

endmodule

@@ design/mcfir_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel FIR merge
// Picks the queried lane, scales its sum and holds the result for transfer.
// ----------------------------------------------------------------------------
module mcfir_merge
  import mcfir_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [ChW-1:0]                       ch,
  input  logic signed [Channels-1:0][AccW-1:0] accs,
  input  logic [Channels-1:0][SampleW-1:0]     raws,
  output logic                                 full,
  input  logic                                 take,
  output logic [ChW-1:0]                       q_ch,
  output logic [SampleW-1:0]                   q_raw,
  output logic signed [OutW-1:0]               q_filt
);

  logic full_r, full_nxt;
  logic [ChW-1:0] ch_r;
  logic [SampleW-1:0] raw_r;
  logic signed [OutW-1:0] filt_r;
  logic signed [AccW-1:0] sel;

  assign sel = accs[ch];

  always_comb begin
    full_nxt = full_r;
    if (take) full_nxt = 1'b0;
    if (load) full_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else full_r <= full_nxt;
    if (load) begin
      ch_r   <= ch;
      raw_r  <= raws[ch];
      filt_r <= OutW'(sel >>> ShiftBits);
    end
  end

  assign full   = full_r;
  assign q_ch   = ch_r;
  assign q_raw  = raw_r;
  assign q_filt = filt_r;

endmodule

@@ design/multichannel_fir_filter.sv @@
`timescale 1ns / 1ps
// A query's result is valid once all its taps are summed (32 taps,
// one multiply-accumulate per cycle in each lane, plus read, product and drain).
// No new item is accepted until a query's result is loaded for output.
// The four lanes run in parallel; the queried lane's sum goes to the output.
// Reset: synchronous active-low rst_n clears pointer, valid bits and control;
// unwritten ring slots read zero and unwritten taps read one.
// ----------------------------------------------------------------------------
// Multichannel FIR filter
// Four-channel, 32-tap FIR with tap writes and per-channel queries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module multichannel_fir_filter
  import mcfir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], sample_ch0..3[41:2], channel_sel[43:42], tap_sel[48:44],
  // tap_weight[64:49]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // query_channel[1:0], raw_value[11:2], filtered_value[27:12]
  output logic [31:0] out_tdata
);

  state_t state_r, state_nxt;
  logic [TapW-1:0] ptr_r, ptr_nxt, cnt_r, cnt_nxt;
  logic [ChW-1:0] qch_r, qch_nxt;
  logic [1:0] drn_r, drn_nxt;
  logic acc_en_r;
  lane_ctrl_t ctrl;
  logic accept, load, full;
  opcode_t op;
  logic [ChW-1:0] chs;
  logic [TapW-1:0] tap_in;
  logic signed [Channels-1:0][AccW-1:0] accs;
  logic [Channels-1:0][SampleW-1:0] raws;
  logic [TapW-1:0] newest;
  logic [ChW-1:0] q_ch;
  logic [SampleW-1:0] q_raw;
  logic signed [OutW-1:0] q_filt;

  assign op     = opcode_t'(in_tdata[1:0]);
  assign chs    = in_tdata[43:42];
  assign tap_in = in_tdata[48:44];
  assign accept = in_tvalid && in_tready;
  assign newest = ptr_r - TapW'(1);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    qch_nxt   = qch_r;
    drn_nxt   = drn_r;
    in_tready = 1'b0;
    load      = 1'b0;
    ctrl      = '0;
    ctrl.wr_ptr    = ptr_r;
    ctrl.coef_ch   = chs;
    ctrl.coef_addr = tap_in;
    ctrl.rd_tap    = cnt_r;
    ctrl.rd_pos    = newest - cnt_r;
    ctrl.acc_en    = acc_en_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          unique case (op)
            OP_SAMPLE: begin
              ctrl.smp_we = 1'b1;
              ptr_nxt = ptr_r + TapW'(1);
            end
            OP_WEIGHT: ctrl.coef_we = 1'b1;
            OP_QUERY: begin
              qch_nxt    = chs;
              cnt_nxt    = '0;
              ctrl.clear = 1'b1;
              state_nxt  = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        ctrl.rd_en = 1'b1;
        cnt_nxt = cnt_r + TapW'(1);
        if (cnt_r == TapW'(Taps - 1)) begin
          drn_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Final products still in the read and multiply stages.
        ctrl.rd_pos = newest;
        drn_nxt = drn_r + 2'd1;
        if (drn_r == 2'd2) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        load = !full || out_tready;
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ptr_r    <= '0;
      cnt_r    <= '0;
      drn_r    <= '0;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      cnt_r    <= cnt_nxt;
      drn_r    <= drn_nxt;
      // Product of a read appears after the read register and the product register.
      acc_en_r <= ctrl.rd_en;
    end
    qch_r <= qch_nxt;
  end

  // The accumulate enable is delayed through acc_en_r and acc_d_r to meet the product.
  logic acc_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) acc_d_r <= 1'b0;
    else acc_d_r <= acc_en_r;
  end

  for (genvar g = 0; g < Channels; g++) begin : g_lane
    lane_ctrl_t lc;
    always_comb begin
      lc = ctrl;
      lc.coef_we = ctrl.coef_we && (ctrl.coef_ch == ChW'(g));
      lc.acc_en = acc_d_r;
    end
    mcfir_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lc),
      .sample (in_tdata[2 + g*SampleW +: SampleW]),
      .weight (in_tdata[64:49]),
      .acc    (accs[g]),
      .newest (raws[g])
    );
  end

  mcfir_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .ch     (qch_r),
    .accs   (accs),
    .raws   (raws),
    .full   (full),
    .take   (out_tready),
    .q_ch   (q_ch),
    .q_raw  (q_raw),
    .q_filt (q_filt)
  );

  assign out_tvalid = full;
  assign out_tdata  = {4'd0, q_filt, q_raw, q_ch};

  `ASSERT_IMP(a_busy_noready, clk, rst_n, state_r != ST_IDLE, !in_tready)
  `ASSERT_NEXT(a_load_full, clk, rst_n, load, out_tvalid)
  `ASSERT_IMP(a_load_free, clk, rst_n, load, !full || out_tready)

endmodule

@@ tb/sv/multichannel_fir_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel FIR filter testbench
// Drives sample groups, tap writes and channel queries into the filter. A
// behavioral copy of the rings and taps predicts every query answer. The
// answers are compared field by field as they leave the output stream.
// ----------------------------------------------------------------------------
module multichannel_fir_filter_test
  import mcfir_pkg::*;
();

  typedef struct packed {
    logic [15:0] filt;
    logic [9:0]  raw;
    logic [1:0]  ch;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [9:0]         ring [Channels][Taps];
  logic signed [15:0] taps [Channels][Taps];
  logic [4:0]         wr_ptr;
  answer_t            pending_answers [$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 hold_off;
  int                 hold_cycles;
  int                 errors;
  longint             cycles;

  multichannel_fir_filter dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic answer_t predict_query(logic [1:0] ch);
    answer_t a;
    logic [4:0] newest;
    logic signed [47:0] sum;
    newest = wr_ptr - 5'd1;
    sum = 0;
    for (int i = 0; i < Taps; i++)
      sum += $signed({38'd0, ring[ch][5'(newest - i)]}) * taps[ch][i];
    sum = sum >>> ShiftBits;
    a.ch = ch;
    a.raw = ring[ch][newest];
    a.filt = sum[15:0];
    return a;
  endfunction

  task automatic send_item(opcode_t op, logic [39:0] smp, logic [1:0] ch,
                           logic [4:0] tap, logic [15:0] w);
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tdata = {7'd0, w, tap, ch, smp, op};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_SAMPLE: begin
        for (int c = 0; c < Channels; c++) ring[c][wr_ptr] = smp[c*10 +: 10];
        wr_ptr = wr_ptr + 5'd1;
      end
      OP_WEIGHT: taps[ch][tap] = w;
      OP_QUERY: pending_answers.push_back(predict_query(ch));
      default: ;
    endcase
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) send_item(OP_SAMPLE, 40'({$urandom, $urandom}), '0, '0, '0);
      else if (k < 65)
        send_item(OP_WEIGHT, 40'({$urandom, $urandom}), 2'($urandom), 5'($urandom),
                  16'($urandom));
      else if (k < 95)
        send_item(OP_QUERY, 40'({$urandom, $urandom}), 2'($urandom), 5'($urandom),
                  16'($urandom));
      else
        send_item(OP_NONE, 40'({$urandom, $urandom}), 2'($urandom), 5'($urandom),
                  16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[27:0];
      if (pending_answers.size() == 0) begin
        $display("%0t: answer expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.ch !== want.ch) begin
          $display("%0t: channel expected %0d actual %0d", $time, want.ch, got.ch);
          errors++;
        end
        if (got.raw !== want.raw) begin
          $display("%0t: raw expected %0d actual %0d", $time, want.raw, got.raw);
          errors++;
        end
        if (got.filt !== want.filt) begin
          $display("%0t: filtered expected %0d actual %0d", $time,
                   $signed(want.filt), $signed(got.filt));
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    send_item(OP_QUERY, '0, 2'd0, '0, '0);
    send_item(OP_SAMPLE, {4{10'h3FF}}, '0, '0, '0);
    send_item(OP_QUERY, '0, 2'd3, '0, '0);
    for (int c = 0; c < Channels; c++) begin
      send_item(OP_WEIGHT, '0, 2'(c), 5'd0, 16'h7FFF);
      send_item(OP_WEIGHT, '0, 2'(c), 5'd31, 16'h8000);
    end
    send_item(OP_SAMPLE, {10'd0, 10'h155, 10'h2AA, 10'd1}, '0, '0, '0);
    for (int c = 0; c < Channels; c++) send_item(OP_QUERY, '0, 2'(c), '0, '0);
    send_item(OP_NONE, '1, 2'd3, 5'd31, 16'hFFFF);
    send_item(OP_WEIGHT, '0, 2'd1, 5'd5, 16'hFFFF);
    send_item(OP_QUERY, '0, 2'd1, '0, '0);
    wait_drained();
  endtask

  task automatic test_wrap_full_scale();
    for (int c = 0; c < Channels; c++)
      for (int t = 0; t < Taps; t++)
        send_item(OP_WEIGHT, '0, 2'(c), 5'(t), c[0] ? 16'h8000 : 16'h7FFF);
    for (int i = 0; i < 34; i++) send_item(OP_SAMPLE, {4{10'h3FF}}, '0, '0, '0);
    for (int c = 0; c < Channels; c++) send_item(OP_QUERY, '0, 2'(c), '0, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 0;
    hold_off = 1'b1;
    fork
      begin
        while (hold_cycles < 400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_item(OP_QUERY, '0, 2'($urandom), '0, '0);
    join
    wait_drained();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 11; recv_idle_pct = 62;
    send_random(90);
    send_idle_pct = 62; recv_idle_pct = 11;
    send_random(90);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(90);
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wr_ptr = '0;
    for (int c = 0; c < Channels; c++)
      for (int t = 0; t < Taps; t++) begin
        ring[c][t] = '0;
        taps[c][t] = 16'sd1;
      end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_wrap_full_scale();
    test_backpressure();
    test_random_traffic();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mcfir_pkg.sv
design/mcfir_lane.sv
design/mcfir_merge.sv
design/multichannel_fir_filter.sv
tb/sv/multichannel_fir_filter_test.sv
